/* rtl/core/bbfrs_pkg.sv */
// Shared types and constants for the bit-plane box fill and run scan block.
package bbfrs_pkg;

    localparam int CFG_W  = 32;   // config data width
    localparam int IDX_W  = 3;    // config register index width
    localparam int RES_W  = 16;   // resolution register width
    localparam int ACT_W  = 3;    // active plane count width
    localparam int SW     = 34;   // signed working width for world arithmetic
    localparam int DIV_W  = 33;   // divider magnitude width
    localparam int DCNT_W = 6;    // divider step counter width
    localparam int RUN_W  = 9;    // run_end port width

    localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_LIMIT_X  = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT_Y  = 3'd3;
    localparam logic [IDX_W-1:0] REG_X_RES    = 3'd4;
    localparam logic [IDX_W-1:0] REG_Y_RES    = 3'd5;
    localparam logic [IDX_W-1:0] REG_ACTIVE   = 3'd6;

    localparam logic [1:0] KIND_PAINT = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_COL   = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_REJ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PAINT_RD,
        ST_PAINT_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        GEO_W_GO,
        GEO_W_WAIT,
        GEO_H_GO,
        GEO_H_WAIT,
        GEO_DONE
    } geo_t;

    typedef enum logic [1:0] {
        JOB_CX0,
        JOB_CX1,
        JOB_CY0,
        JOB_CY1
    } job_t;

endpackage

/* rtl/core/bitplane_box_fill_run_scan_top.sv */
// Bit-plane box fill and run scan: store, divider, sequencer and output register.
// Steps: paint is a dispatch step, four divider passes and a store read and write per
// touched word; a query is a dispatch step, then a read and a check per word or row
// scanned; a reject goes from dispatch straight to finish. The finish state waits while
// the result register is stalled; the beat is valid after it. One item at a time.
// Reset and geometry writes sweep the store to zero, one word per cycle, no items taken.
module bitplane_box_fill_run_scan_top #(
    parameter int NUM_PLANES = 4,
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int WORD_BITS  = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [1:0]                      plane,
    input  logic signed [31:0]              x_a,
    input  logic signed [31:0]              y_a,
    input  logic signed [31:0]              x_b,
    input  logic signed [31:0]              y_b,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            status,
    output logic                            run_color,
    output logic [bbfrs_pkg::RUN_W-1:0]     run_end,
    // config write port
    input  logic                            cfg_we,
    input  logic [bbfrs_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bbfrs_pkg::CFG_W-1:0]     cfg_data
);

    localparam int ROW_WORDS = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH     = NUM_PLANES * MAX_HEIGHT * ROW_WORDS;
    localparam int AW        = $clog2(DEPTH);
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int WIW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int OFW       = $clog2(WORD_BITS);
    localparam int EW0       = (XW > YW) ? XW : YW;
    localparam int EW        = (EW0 > bbfrs_pkg::RUN_W) ? EW0 : bbfrs_pkg::RUN_W;
    localparam int SW        = bbfrs_pkg::SW;
    localparam int DIV_W     = bbfrs_pkg::DIV_W;
    localparam int RES_W     = bbfrs_pkg::RES_W;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic signed [31:0]             origin_x_reg, origin_y_reg, limit_x_reg, limit_y_reg;
    logic [RES_W-1:0]               x_res_reg, y_res_reg;
    logic [bbfrs_pkg::ACT_W-1:0]    active_reg;
    logic                           geo_write;

    // any register but the plane count changes geometry and wipes the store
    assign geo_write = cfg_we && (cfg_index inside {[bbfrs_pkg::REG_ORIGIN_X:
                                                     bbfrs_pkg::REG_Y_RES]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            limit_x_reg  <= 32'sd511;
            limit_y_reg  <= 32'sd511;
            x_res_reg    <= 16'd1;
            y_res_reg    <= 16'd1;
            active_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbfrs_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                bbfrs_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                bbfrs_pkg::REG_LIMIT_X:  limit_x_reg  <= cfg_data;
                bbfrs_pkg::REG_LIMIT_Y:  limit_y_reg  <= cfg_data;
                bbfrs_pkg::REG_X_RES:    x_res_reg    <= cfg_data[RES_W-1:0];
                bbfrs_pkg::REG_Y_RES:    y_res_reg    <= cfg_data[RES_W-1:0];
                bbfrs_pkg::REG_ACTIVE:   active_reg   <= cfg_data[bbfrs_pkg::ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero resolution behaves as one; a limit not above its origin becomes origin + 1
    logic [RES_W-1:0]        rx_eff, ry_eff;
    logic signed [SW-1:0]    xl_eff, yl_eff;

    assign rx_eff = (x_res_reg == '0) ? RES_W'(1) : x_res_reg;
    assign ry_eff = (y_res_reg == '0) ? RES_W'(1) : y_res_reg;
    assign xl_eff = (limit_x_reg <= origin_x_reg) ? SW'(origin_x_reg) + SW'(1)
                                                  : SW'(limit_x_reg);
    assign yl_eff = (limit_y_reg <= origin_y_reg) ? SW'(origin_y_reg) + SW'(1)
                                                  : SW'(limit_y_reg);

    // ------------------------------------------------------------------
    // Sequencer state and item registers
    // ------------------------------------------------------------------
    bbfrs_pkg::state_t  state_reg, state_next;
    bbfrs_pkg::geo_t    geo_reg;
    bbfrs_pkg::job_t    job_reg;

    logic [AW-1:0]      clr_addr_reg;
    logic               clr_fin_reg;
    logic [XW:0]        w_reg;          // pixmap width in pixels
    logic [YW:0]        h_reg;          // pixmap height in pixels

    logic [1:0]         kind_reg, plane_reg;
    logic signed [31:0] x_a_reg, y_a_reg, x_b_reg, y_b_reg;

    logic [XW-1:0]      cx0_reg, cx1_reg, base_reg, base0_reg;
    logic [YW-1:0]      cy0_reg, cy1_reg, cur_row_reg;
    logic [WIW-1:0]     wd_reg, wd0_reg;
    logic [OFW-1:0]     off_reg;
    logic               first_reg, color_reg;

    logic               res_status_reg, res_color_reg;
    logic [EW-1:0]      res_end_reg;

    logic               out_valid_reg, out_status_reg, out_color_reg;
    logic [EW-1:0]      out_end_reg;
    logic               slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Serial restoring divider, one quotient bit per cycle, shared by
    // geometry and corner mapping
    // ------------------------------------------------------------------
    logic                       div_start;
    logic signed [SW-1:0]       div_num;
    logic [RES_W-1:0]           div_den;
    logic [DIV_W-1:0]           div_quo_reg;
    logic [RES_W-1:0]           div_rem_reg, div_den_reg;
    logic                       div_neg_reg;
    logic [bbfrs_pkg::DCNT_W-1:0] div_cnt_reg;
    logic                       div_done;
    logic [RES_W:0]             div_rsh;
    logic                       div_ge;
    logic signed [SW-1:0]       div_q;
    logic [SW-1:0]              div_mag;

    assign div_done = (div_cnt_reg == '0);
    assign div_rsh  = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge   = (div_rsh >= {1'b0, div_den_reg});
    assign div_q    = div_neg_reg ? -$signed(SW'(div_quo_reg)) : $signed(SW'(div_quo_reg));
    assign div_mag  = div_num[SW-1] ? SW'(-div_num) : SW'(div_num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (div_start)
        begin
            div_cnt_reg <= bbfrs_pkg::DCNT_W'(DIV_W);
        end
        else if (!div_done)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_quo_reg <= div_mag[DIV_W-1:0];
            div_rem_reg <= '0;
            div_den_reg <= div_den;
            div_neg_reg <= div_num[SW-1];
        end
        else if (!div_done)
        begin
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], div_ge};
            div_rem_reg <= div_ge ? RES_W'(div_rsh - {1'b0, div_den_reg})
                                  : div_rsh[RES_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pixel store: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0]   mem [DEPTH];
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, item_addr;
    logic [WORD_BITS-1:0]   mem_wdata, mem_rdata;

    assign item_addr = AW'((AW'(plane_reg) * AW'(MAX_HEIGHT) + AW'(cur_row_reg))
                           * AW'(ROW_WORDS) + AW'(wd_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[item_addr];
    end

    // ------------------------------------------------------------------
    // Item checks
    // ------------------------------------------------------------------
    logic                   plane_ok, item_bad, paint_miss, query_oob;
    logic signed [31:0]     x_lo, x_hi, y_lo, y_hi;

    assign plane_ok   = ({1'b0, plane_reg} < active_reg) && (32'(plane_reg) < NUM_PLANES);
    assign item_bad   = !plane_ok || !(kind_reg inside {bbfrs_pkg::KIND_PAINT,
                                                        bbfrs_pkg::KIND_ROW,
                                                        bbfrs_pkg::KIND_COL});
    assign x_lo       = (x_a_reg > x_b_reg) ? x_b_reg : x_a_reg;
    assign x_hi       = (x_a_reg > x_b_reg) ? x_a_reg : x_b_reg;
    assign y_lo       = (y_a_reg > y_b_reg) ? y_b_reg : y_a_reg;
    assign y_hi       = (y_a_reg > y_b_reg) ? y_a_reg : y_b_reg;
    assign paint_miss = (x_hi < origin_x_reg) || (SW'(x_lo) > xl_eff)
                     || (y_hi < origin_y_reg) || (SW'(y_lo) > yl_eff);
    assign query_oob  = x_a_reg[31] || y_a_reg[31]
                     || ({1'b0, x_a_reg} >= 33'(w_reg))
                     || ({1'b0, y_a_reg} >= 33'(h_reg));

    // quotient clamped into the pixmap
    logic [XW-1:0]  q_clamp_x;
    logic [YW-1:0]  q_clamp_y;

    assign q_clamp_x = div_q[SW-1] ? '0
                     : ($unsigned(div_q) > SW'(w_reg - 1'b1)) ? XW'(w_reg - 1'b1)
                     : XW'(div_q);
    assign q_clamp_y = div_q[SW-1] ? '0
                     : ($unsigned(div_q) > SW'(h_reg - 1'b1)) ? YW'(h_reg - 1'b1)
                     : YW'(div_q);

    // word index and word start of a pixel column: shift and mask
    logic [XW-1:0]  word_mask;

    assign word_mask = ~XW'(WORD_BITS - 1);

    // ------------------------------------------------------------------
    // Paint word: mask of covered pixels, MSB first
    // ------------------------------------------------------------------
    logic [XW:0]            word_end;
    logic                   last_word;
    logic [OFW-1:0]         pa, pb;
    logic [WORD_BITS-1:0]   paint_mask;

    assign word_end  = (XW+1)'(base_reg) + (XW+1)'(WORD_BITS - 1);
    assign last_word = (word_end >= (XW+1)'(cx1_reg));
    assign pa = (cx0_reg > base_reg) ? OFW'(cx0_reg - base_reg) : '0;
    assign pb = last_word ? OFW'(cx1_reg - base_reg) : OFW'(WORD_BITS - 1);

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            paint_mask[WORD_BITS-1-i] = (OFW'(i) >= pa) && (OFW'(i) <= pb);
        end
    end

    // ------------------------------------------------------------------
    // Scan word: colour and first change at or after the start offset
    // ------------------------------------------------------------------
    logic                   pix_bit, color_now, found;
    logic [WORD_BITS-1:0]   diff;
    logic [OFW-1:0]         pos;
    logic                   scan_done;
    logic [EW-1:0]          scan_end;
    logic [XW:0]            row_hit, w_last;
    logic [YW:0]            row_nxt;

    assign pix_bit   = mem_rdata[OFW'(WORD_BITS - 1) - off_reg];
    assign color_now = first_reg ? pix_bit : color_reg;
    assign diff      = mem_rdata ^ {WORD_BITS{color_now}};
    assign w_last    = w_reg - 1'b1;
    assign row_hit   = (XW+1)'(base_reg) + (XW+1)'(pos) - 1'b1;
    assign row_nxt   = (YW+1)'(cur_row_reg) + 1'b1;

    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        // descending so the lowest pixel index wins
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (diff[WORD_BITS-1-i] && (OFW'(i) >= off_reg))
            begin
                found = 1'b1;
                pos   = OFW'(i);
            end
        end
    end

    always_comb
    begin
        scan_done = 1'b0;
        scan_end  = '0;
        if (kind_reg == bbfrs_pkg::KIND_ROW)
        begin
            if (found)
            begin
                scan_done = 1'b1;
                scan_end  = (row_hit > w_last) ? EW'(w_last) : EW'(row_hit);
            end
            else if (word_end >= w_last)
            begin
                scan_done = 1'b1;
                scan_end  = EW'(w_last);
            end
        end
        else
        begin
            if (!first_reg && (pix_bit != color_reg))
            begin
                scan_done = 1'b1;
                scan_end  = EW'(cur_row_reg - 1'b1);
            end
            else if (row_nxt >= h_reg)
            begin
                scan_done = 1'b1;
                scan_end  = EW'(cur_row_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bbfrs_pkg::ST_CLEAR:
                if (clr_fin_reg && (geo_reg == bbfrs_pkg::GEO_DONE))
                    state_next = bbfrs_pkg::ST_IDLE;
            bbfrs_pkg::ST_IDLE:
                if (in_valid)
                    state_next = bbfrs_pkg::ST_DISPATCH;
            bbfrs_pkg::ST_DISPATCH:
                if (item_bad)
                    state_next = bbfrs_pkg::ST_FINISH;
                else if (kind_reg == bbfrs_pkg::KIND_PAINT)
                    state_next = paint_miss ? bbfrs_pkg::ST_FINISH : bbfrs_pkg::ST_DIV_GO;
                else
                    state_next = query_oob ? bbfrs_pkg::ST_FINISH : bbfrs_pkg::ST_SCAN_RD;
            bbfrs_pkg::ST_DIV_GO:
                state_next = bbfrs_pkg::ST_DIV_WAIT;
            bbfrs_pkg::ST_DIV_WAIT:
                if (div_done)
                begin
                    case (job_reg)
                        bbfrs_pkg::JOB_CY1: state_next = bbfrs_pkg::ST_PAINT_RD;
                        default:            state_next = bbfrs_pkg::ST_DIV_GO;
                    endcase
                end
            bbfrs_pkg::ST_PAINT_RD:
                state_next = bbfrs_pkg::ST_PAINT_WR;
            bbfrs_pkg::ST_PAINT_WR:
                state_next = (last_word && (cur_row_reg == cy1_reg))
                           ? bbfrs_pkg::ST_FINISH : bbfrs_pkg::ST_PAINT_RD;
            bbfrs_pkg::ST_SCAN_RD:
                state_next = bbfrs_pkg::ST_SCAN_CHK;
            bbfrs_pkg::ST_SCAN_CHK:
                state_next = scan_done ? bbfrs_pkg::ST_FINISH : bbfrs_pkg::ST_SCAN_RD;
            bbfrs_pkg::ST_FINISH:
                if (slot_free)
                    state_next = bbfrs_pkg::ST_IDLE;
            default:
                state_next = bbfrs_pkg::ST_CLEAR;
        endcase
        if (geo_write)
            state_next = bbfrs_pkg::ST_CLEAR;
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: handshake, store port, divider operands
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = (state_reg != bbfrs_pkg::ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = item_addr;
        mem_wdata = mem_rdata | paint_mask;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = rx_eff;
        case (state_reg)
            bbfrs_pkg::ST_CLEAR:
            begin
                mem_we    = !clr_fin_reg;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                div_start = (geo_reg == bbfrs_pkg::GEO_W_GO)
                         || (geo_reg == bbfrs_pkg::GEO_H_GO);
                if (geo_reg == bbfrs_pkg::GEO_H_GO)
                begin
                    div_num = yl_eff - SW'(origin_y_reg) + SW'(ry_eff);
                    div_den = ry_eff;
                end
                else
                begin
                    div_num = xl_eff - SW'(origin_x_reg) + SW'(rx_eff);
                    div_den = rx_eff;
                end
            end
            bbfrs_pkg::ST_DIV_GO:
            begin
                div_start = 1'b1;
                case (job_reg)
                    bbfrs_pkg::JOB_CX0:
                        div_num = SW'(x_lo) - SW'(origin_x_reg);
                    bbfrs_pkg::JOB_CX1:
                        div_num = SW'(x_hi) - SW'(origin_x_reg);
                    bbfrs_pkg::JOB_CY0:
                    begin
                        div_num = SW'(y_lo) - SW'(origin_y_reg);
                        div_den = ry_eff;
                    end
                    default:
                    begin
                        div_num = SW'(y_hi) - SW'(origin_y_reg);
                        div_den = ry_eff;
                    end
                endcase
            end
            bbfrs_pkg::ST_PAINT_WR:
                mem_we = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers: state, clear sweep, geometry jobs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bbfrs_pkg::ST_CLEAR;
            geo_reg      <= bbfrs_pkg::GEO_W_GO;
            clr_addr_reg <= '0;
            clr_fin_reg  <= 1'b0;
            w_reg        <= (XW+1)'(MAX_WIDTH);
            h_reg        <= (YW+1)'(MAX_HEIGHT);
        end
        else
        begin
            state_reg <= state_next;
            if (geo_write)
            begin
                geo_reg      <= bbfrs_pkg::GEO_W_GO;
                clr_addr_reg <= '0;
                clr_fin_reg  <= 1'b0;
            end
            else if (state_reg == bbfrs_pkg::ST_CLEAR)
            begin
                if (!clr_fin_reg)
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    clr_fin_reg  <= (clr_addr_reg == AW'(DEPTH - 1));
                end
                case (geo_reg)
                    bbfrs_pkg::GEO_W_GO: geo_reg <= bbfrs_pkg::GEO_W_WAIT;
                    bbfrs_pkg::GEO_W_WAIT:
                        if (div_done)
                        begin
                            w_reg   <= ($unsigned(div_q) > SW'(MAX_WIDTH))
                                     ? (XW+1)'(MAX_WIDTH) : (XW+1)'(div_q);
                            geo_reg <= bbfrs_pkg::GEO_H_GO;
                        end
                    bbfrs_pkg::GEO_H_GO: geo_reg <= bbfrs_pkg::GEO_H_WAIT;
                    bbfrs_pkg::GEO_H_WAIT:
                        if (div_done)
                        begin
                            h_reg   <= ($unsigned(div_q) > SW'(MAX_HEIGHT))
                                     ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(div_q);
                            geo_reg <= bbfrs_pkg::GEO_DONE;
                        end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Item datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bbfrs_pkg::ST_IDLE:
            begin
                kind_reg  <= kind;
                plane_reg <= plane;
                x_a_reg   <= x_a;
                y_a_reg   <= y_a;
                x_b_reg   <= x_b;
                y_b_reg   <= y_b;
            end
            bbfrs_pkg::ST_DISPATCH:
            begin
                res_status_reg <= bbfrs_pkg::STATUS_REJ;
                res_color_reg  <= 1'b0;
                res_end_reg    <= '0;
                job_reg        <= bbfrs_pkg::JOB_CX0;
                // query start: word index and pixel offset of x_a
                wd_reg         <= WIW'(x_a_reg[31:OFW]);
                off_reg        <= x_a_reg[OFW-1:0];
                base_reg       <= XW'(x_a_reg) & word_mask;
                cur_row_reg    <= YW'(y_a_reg);
                first_reg      <= 1'b1;
            end
            bbfrs_pkg::ST_DIV_WAIT:
                if (div_done)
                begin
                    case (job_reg)
                        bbfrs_pkg::JOB_CX0:
                        begin
                            cx0_reg <= q_clamp_x;
                            job_reg <= bbfrs_pkg::JOB_CX1;
                        end
                        bbfrs_pkg::JOB_CX1:
                        begin
                            cx1_reg <= q_clamp_x;
                            job_reg <= bbfrs_pkg::JOB_CY0;
                        end
                        bbfrs_pkg::JOB_CY0:
                        begin
                            cy0_reg <= q_clamp_y;
                            job_reg <= bbfrs_pkg::JOB_CY1;
                        end
                        default:
                        begin
                            cy1_reg     <= q_clamp_y;
                            wd_reg      <= WIW'(cx0_reg >> OFW);
                            wd0_reg     <= WIW'(cx0_reg >> OFW);
                            base_reg    <= cx0_reg & word_mask;
                            base0_reg   <= cx0_reg & word_mask;
                            cur_row_reg <= cy0_reg;
                        end
                    endcase
                end
            bbfrs_pkg::ST_PAINT_WR:
                if (last_word)
                begin
                    if (cur_row_reg == cy1_reg)
                    begin
                        res_status_reg <= bbfrs_pkg::STATUS_OK;
                    end
                    else
                    begin
                        cur_row_reg <= cur_row_reg + 1'b1;
                        wd_reg      <= wd0_reg;
                        base_reg    <= base0_reg;
                    end
                end
                else
                begin
                    wd_reg   <= wd_reg + 1'b1;
                    base_reg <= base_reg + XW'(WORD_BITS);
                end
            bbfrs_pkg::ST_SCAN_CHK:
            begin
                first_reg <= 1'b0;
                color_reg <= color_now;
                if (scan_done)
                begin
                    res_status_reg <= bbfrs_pkg::STATUS_OK;
                    res_color_reg  <= color_now;
                    res_end_reg    <= scan_end;
                end
                else if (kind_reg == bbfrs_pkg::KIND_ROW)
                begin
                    wd_reg   <= wd_reg + 1'b1;
                    base_reg <= base_reg + XW'(WORD_BITS);
                    off_reg  <= '0;
                end
                else
                begin
                    cur_row_reg <= cur_row_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: holds one result beat while the sink stalls
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == bbfrs_pkg::ST_FINISH) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == bbfrs_pkg::ST_FINISH) && slot_free)
        begin
            out_status_reg <= res_status_reg;
            out_color_reg  <= res_color_reg;
            out_end_reg    <= res_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign run_color = out_color_reg;
    assign run_end   = out_end_reg[bbfrs_pkg::RUN_W-1:0];

endmodule
